// File: hdl/pearson_correlation_distance_assert.svh
// Assertion macros for the correlation distance block
`ifndef PEARSON_CORRELATION_DISTANCE_ASSERT_SVH
`define PEARSON_CORRELATION_DISTANCE_ASSERT_SVH

// same-cycle implication
`define PCD_AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcd assertion failed");

// next-cycle implication
`define PCD_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcd assertion failed");

`endif

// File: hdl/pcd_pkg.sv
// Shared types and constants of the correlation distance block
package pcd_pkg;

  localparam int Q_FRAC = 15;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef enum logic [2:0] {
    OP_VX_A = 3'd0,
    OP_VX_B = 3'd1,
    OP_VY_A = 3'd2,
    OP_VY_B = 3'd3,
    OP_DEN  = 3'd4,
    OP_P    = 3'd5,
    OP_S    = 3'd6,
    OP_NUM2 = 3'd7
  } op_t;

  typedef struct packed {
    logic       take;
    logic       mul_load;
    logic       mul_step;
    logic       mul_store;
    op_t        op;
    logic       root_init;
    logic       root_a;
    logic       root_b;
    logic [3:0] bit_idx;
    logic       out_load;
    logic       clear;
  } cmd_t;

endpackage

// File: hdl/pcd_dpath.sv
// Datapath: accumulators, serial multiplier and bitwise root search
module pcd_dpath #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pcd_pkg::cmd_t          cmd,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  output logic [15:0]            distance,
  output logic                   degenerate
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_PAIRS + 1);
  localparam int SXW  = SB + CW;
  localparam int SQW  = 2 * SB - 2 + CW;
  localparam int SXYW = SQW + 1;
  localparam int PW   = 2 * SB;
  localparam int MW   = 2 * SXW + 1;
  localparam int RW   = 2 * MW + 31;

  logic signed [PW-1:0] xe, ye, mxy, mxx, myy;
  logic signed [SB-1:0] px, py;
  logic signed [PW-1:0] pxy;
  logic [PW-2:0]        pxx, pyy;
  logic                 stg_v;

  logic [CW-1:0]          cnt;
  logic signed [SXW-1:0]  sx, sy;
  logic signed [SXYW-1:0] sxy;
  logic [SQW-1:0]         sxx, syy;
  logic [SXW-1:0]         absx, absy;
  logic [SXYW-1:0]        absxy;

  logic [MW-1:0]   a_op, a_next, b_next;
  logic [2*MW-1:0] prod, t1, den, n2;
  logic [MW:0]     psum;
  logic [MW-1:0]   vx, vy, num;
  logic            degen;

  logic [RW-1:0] qqd, qd, tmp, test, nbig;
  logic [15:0]   q;

  assign xe  = {{SB{x_sample[SB-1]}}, x_sample};
  assign ye  = {{SB{y_sample[SB-1]}}, y_sample};
  assign mxy = xe * ye;
  assign mxx = xe * xe;
  assign myy = ye * ye;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= 1'b0;
    end else begin
      stg_v <= cmd.take;
    end
    if (cmd.take) begin
      px  <= x_sample;
      py  <= y_sample;
      pxy <= mxy;
      pxx <= mxx[PW-2:0];
      pyy <= myy[PW-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt <= '0;
      sx  <= '0;
      sy  <= '0;
      sxy <= '0;
      sxx <= '0;
      syy <= '0;
    end else if (stg_v && cnt < CW'(MAX_PAIRS)) begin
      cnt <= cnt + 1'b1;
      sx  <= sx + {{(SXW-SB){px[SB-1]}}, px};
      sy  <= sy + {{(SXW-SB){py[SB-1]}}, py};
      sxy <= sxy + {{(SXYW-PW){pxy[PW-1]}}, pxy};
      sxx <= sxx + {{(CW-1){1'b0}}, pxx};
      syy <= syy + {{(CW-1){1'b0}}, pyy};
    end
  end

  assign absx  = sx[SXW-1] ? -sx : sx;
  assign absy  = sy[SXW-1] ? -sy : sy;
  assign absxy = sxy[SXYW-1] ? -sxy : sxy;

  always_comb begin
    unique case (cmd.op)
      pcd_pkg::OP_VX_A: begin
        a_next = MW'(cnt);
        b_next = MW'(sxx);
      end
      pcd_pkg::OP_VX_B: begin
        a_next = MW'(absx);
        b_next = MW'(absx);
      end
      pcd_pkg::OP_VY_A: begin
        a_next = MW'(cnt);
        b_next = MW'(syy);
      end
      pcd_pkg::OP_VY_B: begin
        a_next = MW'(absy);
        b_next = MW'(absy);
      end
      pcd_pkg::OP_DEN: begin
        a_next = vx;
        b_next = vy;
      end
      pcd_pkg::OP_P: begin
        a_next = MW'(cnt);
        b_next = MW'(absxy);
      end
      pcd_pkg::OP_S: begin
        a_next = MW'(absx);
        b_next = MW'(absy);
      end
      pcd_pkg::OP_NUM2: begin
        a_next = num;
        b_next = num;
      end
      default: begin
        a_next = '0;
        b_next = '0;
      end
    endcase
  end

  assign psum = {1'b0, prod[2*MW-1:MW]} + (prod[0] ? {1'b0, a_op} : '0);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      a_op <= a_next;
      prod <= {{MW{1'b0}}, b_next};
    end else if (cmd.mul_step) begin
      prod <= {psum, prod[MW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      degen <= 1'b0;
    end else if (cmd.mul_store) begin
      case (cmd.op) inside
        pcd_pkg::OP_VX_A, pcd_pkg::OP_VY_A, pcd_pkg::OP_P: t1 <= prod;
        pcd_pkg::OP_VX_B: begin
          if (t1 <= prod) degen <= 1'b1;
          vx <= MW'(t1 - prod);
        end
        pcd_pkg::OP_VY_B: begin
          if (t1 <= prod) degen <= 1'b1;
          vy <= MW'(t1 - prod);
        end
        pcd_pkg::OP_DEN: den <= prod;
        pcd_pkg::OP_S: begin
          if (sxy[SXYW-1] ^ sx[SXW-1] ^ sy[SXW-1]) begin
            num <= MW'(t1 + prod);
          end else if (t1 >= prod) begin
            num <= MW'(t1 - prod);
          end else begin
            num <= MW'(prod - t1);
          end
        end
        pcd_pkg::OP_NUM2: n2 <= prod;
        default: ;
      endcase
    end
  end

  assign nbig = {n2, 30'b0} & {RW{1'b1}};
  assign test = tmp + (RW'(den) << {cmd.bit_idx, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      q   <= '0;
      qqd <= '0;
      qd  <= '0;
    end else if (cmd.root_a) begin
      tmp <= qqd + (qd << (5'(cmd.bit_idx) + 5'd1));
    end else if (cmd.root_b && test <= nbig) begin
      q   <= q | (16'd1 << cmd.bit_idx);
      qqd <= test;
      qd  <= qd + (RW'(den) << cmd.bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      degenerate <= degen;
      if (degen || den <= n2) begin
        distance <= degen ? pcd_pkg::ONE_Q15 : 16'd0;
      end else begin
        distance <= pcd_pkg::ONE_Q15 - q;
      end
    end
  end

endmodule

// File: hdl/pcd_ctrl.sv
// Controller: sequences accumulation drain, multiplies and root search
module pcd_ctrl #(
  parameter int MUL_STEPS = 59
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last_pair,
  output logic          busy,
  output logic          done,
  output pcd_pkg::cmd_t cmd
);

  localparam int MCW = $clog2(MUL_STEPS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DRAIN = 10'b0000000010,
    S_LOAD  = 10'b0000000100,
    S_RUN   = 10'b0000001000,
    S_STORE = 10'b0000010000,
    S_RINIT = 10'b0000100000,
    S_RA    = 10'b0001000000,
    S_RB    = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t           state, state_next;
  pcd_pkg::op_t     op;
  logic [MCW-1:0]   mcnt;
  logic [3:0]       bidx;

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start && last_pair) state_next = S_DRAIN;
      S_DRAIN: state_next = S_LOAD;
      S_LOAD:  state_next = S_RUN;
      S_RUN:   if (mcnt == MCW'(MUL_STEPS - 1)) state_next = S_STORE;
      S_STORE: state_next = (op == pcd_pkg::OP_NUM2) ? S_RINIT : S_LOAD;
      S_RINIT: state_next = S_RA;
      S_RA:    state_next = S_RB;
      S_RB:    state_next = (bidx == 4'd0) ? S_FIN : S_RA;
      S_FIN:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= pcd_pkg::OP_VX_A;
      mcnt  <= '0;
      bidx  <= '0;
    end else begin
      state <= state_next;
      if (state == S_DRAIN) op <= pcd_pkg::OP_VX_A;
      if (state == S_STORE) op <= pcd_pkg::op_t'(op + 3'd1);
      if (state == S_RUN) mcnt <= mcnt + 1'b1;
      else mcnt <= '0;
      if (state == S_RINIT) bidx <= 4'(pcd_pkg::Q_FRAC - 1);
      else if (state == S_RB) bidx <= bidx - 1'b1;
    end
  end

  always_comb begin
    cmd.take      = start && !busy;
    cmd.mul_load  = (state == S_LOAD);
    cmd.mul_step  = (state == S_RUN);
    cmd.mul_store = (state == S_STORE);
    cmd.op        = op;
    cmd.root_init = (state == S_RINIT);
    cmd.root_a    = (state == S_RA);
    cmd.root_b    = (state == S_RB);
    cmd.bit_idx   = bidx;
    cmd.out_load  = (state == S_FIN);
    cmd.clear     = (state == S_OUT);
  end

endmodule

// File: hdl/pearson_correlation_distance.sv
// Top level of the Pearson correlation distance block
//
//   channel  dir  handshake          payload
//   item     in   start, busy        x_sample, y_sample, last_pair
//   result   out  done (strobe)      distance, degenerate
//
// A pair without last_pair is taken every cycle; busy stays low.
// A last pair raises busy while eight products pass through the bit-serial
// multiplier and then through the root search, which takes an S_RA and an
// S_RB step for each result bit.
// done pulses for one cycle in the final busy cycle; sums clear then.
// Synchronous reset clears sums and control; the receiver cannot stall.
module pearson_correlation_distance #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic                   last_pair,
  output logic                   done,
  output logic [15:0]            distance,
  output logic                   degenerate
);

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int MW = 2 * (SAMPLE_BITS + CW) + 1;

  pcd_pkg::cmd_t cmd;

  pcd_ctrl #(
    .MUL_STEPS(MW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_pair (last_pair),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  pcd_dpath #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .x_sample   (x_sample),
    .y_sample   (y_sample),
    .distance   (distance),
    .degenerate (degenerate)
  );

endmodule

// File: hdl/pcd_checker.sv
// Port-level checker for the correlation distance block
`include "pearson_correlation_distance_assert.svh"

module pcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        last_pair,
  input logic        done,
  input logic [15:0] distance,
  input logic        degenerate
);

  `PCD_AST_NOW(a_done_busy, done, busy)
  `PCD_AST_NEXT(a_done_single, done, !done)
  `PCD_AST_NEXT(a_plain_no_result, start && !busy && !last_pair, !done && !busy)
  `PCD_AST_NEXT(a_last_busy, start && !busy && last_pair, busy)
  `PCD_AST_NOW(a_degen_one, done && degenerate, distance == 16'h8000)

endmodule

bind pearson_correlation_distance pcd_checker u_pcd_checker (.*);

// File: verif/pearson_correlation_distance_tb.sv
// Testbench for pearson_correlation_distance: queue-fed driver, done monitor, scoreboard
module pearson_correlation_distance_tb;

  localparam int N_MAX    = 4096;
  localparam int WD_LIMIT = 40000;

  typedef logic [159:0] wide_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          last;
    int unsigned gap;
    bit          drain;
  } pair_beat_t;

  typedef struct {
    logic [15:0] dval;
    bit          degen;
  } dist_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] x_sample = '0;
  logic [15:0] y_sample = '0;
  logic        last_pair = 1'b0;
  logic        done;
  logic [15:0] distance;
  logic        degenerate;

  pair_beat_t   pending_pairs[$];
  dist_result_t expected_dist[$];

  int unsigned n_pairs;
  longint      acc_x, acc_y, acc_xy, acc_xx, acc_yy;
  int          errors = 0;
  int          pairs_sent = 0;
  int          vectors_checked = 0;
  int          degen_seen = 0;
  int unsigned gap_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          stim_done = 1'b0;

  pearson_correlation_distance dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_sample(x_sample), .y_sample(y_sample), .last_pair(last_pair),
    .done(done), .distance(distance), .degenerate(degenerate)
  );

  always #10 clk = ~clk;

  function automatic wide_t mag_w(longint v);
    return (v < 0) ? wide_t'(-v) : wide_t'(v);
  endfunction

  function automatic dist_result_t corr_distance();
    dist_result_t r;
    wide_t a, b, vx, vy, den, p, s, num, num2;
    logic [31:0] q, t;
    r.degen = 1'b0;
    a = wide_t'(n_pairs) * mag_w(acc_xx);
    b = mag_w(acc_x) * mag_w(acc_x);
    if (acc_xx < 0 || a <= b) r.degen = 1'b1;
    vx = a - b;
    a = wide_t'(n_pairs) * mag_w(acc_yy);
    b = mag_w(acc_y) * mag_w(acc_y);
    if (acc_yy < 0 || a <= b) r.degen = 1'b1;
    vy = a - b;
    if (r.degen) begin
      r.dval = pcd_pkg::ONE_Q15;
      return r;
    end
    den = vx * vy;
    p = wide_t'(n_pairs) * mag_w(acc_xy);
    s = mag_w(acc_x) * mag_w(acc_y);
    if ((acc_xy < 0) != ((acc_x < 0) != (acc_y < 0))) num = p + s;
    else if (p >= s) num = p - s;
    else num = s - p;
    num2 = (num * num) << 30;
    q = 0;
    for (int bt = 14; bt >= 0; bt--) begin
      t = q | (32'd1 << bt);
      if (wide_t'(t * t) * den <= num2) q = t;
    end
    if (wide_t'(32'd1 << 30) * den <= num2) q = 32'd32768;
    r.dval = 16'(32'd32768 - q);
    return r;
  endfunction

  task automatic take_pair(input logic [15:0] xs, input logic [15:0] ys, input bit lst);
    longint xv, yv;
    xv = longint'($signed(xs));
    yv = longint'($signed(ys));
    if (n_pairs < N_MAX) begin
      n_pairs++;
      acc_x += xv;
      acc_y += yv;
      acc_xy += xv * yv;
      acc_xx += xv * xv;
      acc_yy += yv * yv;
    end
    if (lst) begin
      expected_dist.push_back(corr_distance());
      n_pairs = 0;
      acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_cnt = 0;
      n_pairs = 0;
      acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
    end else begin
      if (start && !busy) begin
        take_pair(x_sample, y_sample, last_pair);
        pairs_sent++;
      end
      if (!start || !busy) begin
        if (pending_pairs.size() == 0) begin
          start <= 1'b0;
        end else if (gap_cnt < pending_pairs[0].gap) begin
          gap_cnt++;
          start <= 1'b0;
        end else if (pending_pairs[0].drain && expected_dist.size() != 0) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          x_sample <= pending_pairs[0].x;
          y_sample <= pending_pairs[0].y;
          last_pair <= pending_pairs[0].last;
          pending_pairs.pop_front();
          gap_cnt = 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_dist.size() == 0) begin
        $display("%0t: unexpected result distance=%0d degenerate=%0b",
                 $time, distance, degenerate);
        errors++;
      end else begin
        if (distance !== expected_dist[0].dval) begin
          $display("%0t: distance mismatch exp=%0d act=%0d",
                   $time, expected_dist[0].dval, distance);
          errors++;
        end
        if (degenerate !== expected_dist[0].degen) begin
          $display("%0t: degenerate mismatch exp=%0b act=%0b",
                   $time, expected_dist[0].degen, degenerate);
          errors++;
        end
        if (expected_dist[0].degen) degen_seen++;
        expected_dist.pop_front();
        vectors_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL pearson_correlation_distance");
      $finish;
    end
  end

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic add_pair(input logic [15:0] xs, input logic [15:0] ys, input bit lst);
    pair_beat_t pb;
    pb.x = xs; pb.y = ys; pb.last = lst; pb.gap = rand_gap(); pb.drain = 1'b0;
    pending_pairs.push_back(pb);
  endtask

  task automatic add_vector(input int len, input int kind);
    logic [15:0] xs, ys, cx;
    int sl;
    cx = 16'($urandom);
    sl = int'($urandom_range(0, 6)) - 3;
    for (int i = 0; i < len; i++) begin
      xs = 16'($urandom);
      case (kind)
        0: ys = 16'($urandom);
        1: ys = xs;
        2: ys = 16'(-$signed(xs));
        3: begin
          xs = 16'($signed(16'($urandom)) >>> 3);
          ys = 16'($signed(xs) * sl + $signed(16'($urandom_range(0, 63))) - 32);
        end
        4: begin
          xs = cx;
          ys = 16'($urandom);
        end
        default: begin
          xs = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          ys = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        end
      endcase
      add_pair(xs, ys, i == len - 1);
    end
  endtask

  initial begin
    pair_beat_t pb;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single pair, constant vectors, perfect and inverse correlation, extremes
    add_pair(16'h1234, 16'h4321, 1'b1);
    add_pair(16'h0005, 16'h0001, 1'b0);
    add_pair(16'h0005, 16'h0007, 1'b1);
    add_pair(16'h8000, 16'h8000, 1'b0);
    add_pair(16'h7fff, 16'h7fff, 1'b1);
    add_pair(16'h8000, 16'h7fff, 1'b0);
    add_pair(16'h7fff, 16'h8000, 1'b0);
    add_pair(16'h0000, 16'h0000, 1'b1);
    add_pair(16'h8000, 16'hffff, 1'b0);
    add_pair(16'h7fff, 16'h0001, 1'b0);
    add_pair(16'h0000, 16'h8000, 1'b1);
    add_pair(16'h0000, 16'h0000, 1'b0);
    add_pair(16'h0000, 16'h0000, 1'b1);
    add_vector(4, 1);
    add_vector(4, 2);
    add_vector(5, 3);

    // pair count saturates; the tail pairs must be ignored
    for (int i = 0; i < N_MAX + 3; i++)
      add_pair(16'($urandom), 16'($urandom), i == N_MAX + 2);
    pending_pairs[pending_pairs.size() - 1].gap = 0;

    // hold off until the pipeline is empty
    pb.x = 16'h0100; pb.y = 16'hff00; pb.last = 1'b1; pb.gap = 0; pb.drain = 1'b1;
    pending_pairs.push_back(pb);

    while (pending_pairs.size() < N_MAX + 40 + 1300) begin
      if ($urandom_range(0, 9) == 0) begin
        add_pair(16'($urandom), 16'($urandom), 1'b1);
      end else begin
        add_vector($urandom_range(2, 16), $urandom_range(0, 5));
        if ($urandom_range(0, 19) == 0) pending_pairs[pending_pairs.size() - 1].drain = 1'b1;
        if ($urandom_range(0, 7) == 0)
          for (int i = pending_pairs.size() - 16; i < pending_pairs.size(); i++)
            if (i >= 0) pending_pairs[i].gap = 0;
      end
    end

    wait (pending_pairs.size() == 0 && !start && expected_dist.size() == 0);
    repeat (600) @(posedge clk);
    $display("Sent %0d pairs; checked %0d vectors (%0d degenerate), incl. count saturation.",
             pairs_sent, vectors_checked, degen_seen);
    if (errors == 0 && expected_dist.size() == 0) begin
      $display("PASS pearson_correlation_distance");
    end else begin
      $display("FAIL pearson_correlation_distance");
    end
    $finish;
  end

endmodule
